[sv/hrlp_pkg.sv]
package hrlp_pkg;

    localparam int NUM_METHODS = 9;
    localparam int NUM_VERSIONS = 2;
    localparam int TEXT_CHARS = 8;

    // Parse phase of the current line. Code 7 is unused and behaves like
    // PH_TRAILING.
    typedef enum logic [2:0] {
        PH_PRE_METHOD  = 3'd0,
        PH_METHOD      = 3'd1,
        PH_PRE_TARGET  = 3'd2,
        PH_TARGET      = 3'd3,
        PH_PRE_VERSION = 3'd4,
        PH_VERSION     = 3'd5,
        PH_TRAILING    = 3'd6
    } t_phase;

    typedef struct packed {
        logic       target_valid;
        logic [7:0] target_byte;
        logic       line_done;
        logic       accepted;
        logic [3:0] method_code;
        logic       version_code;
    } t_result;

    // Lower-case method names, one character per entry, padded with zeros.
    localparam logic [7:0] METHOD_TEXT [NUM_METHODS][TEXT_CHARS] = '{
        '{"g", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"h", "e", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "o", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "e", "l", "e", "t", "e", 8'h00, 8'h00},
        '{"c", "o", "n", "n", "e", "c", "t", 8'h00},
        '{"o", "p", "t", "i", "o", "n", "s", 8'h00},
        '{"t", "r", "a", "c", "e", 8'h00, 8'h00, 8'h00},
        '{"p", "a", "t", "c", "h", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
    };

    // Index 0 is HTTP/1.0, index 1 is HTTP/1.1.
    localparam logic [7:0] VERSION_TEXT [NUM_VERSIONS][TEXT_CHARS] = '{
        '{"H", "T", "T", "P", "/", "1", ".", "0"},
        '{"H", "T", "T", "P", "/", "1", ".", "1"}
    };

    localparam logic [3:0] VERSION_LEN = 4'd8;
    localparam logic [3:0] POS_MAX = 4'd15;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

[sv/http_request_line_parser_unit.sv]
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid/tready          tdata = line byte, tlast = last byte of line
// m_axis   out  tvalid/tready          tdata = target byte, accepted, method, version;
//                                      tuser = target byte flag, tlast = line done
//
// Every input item produces exactly one result item. An accepted item is held in the
// input register and moves into the result register, which drives m_axis, once that
// register is empty or being drained. One item is taken per clock while m_axis is not
// stalled; the parse state update is a single pass of compare logic that sits between
// the input register and the result register.
// Reset is synchronous and active low; it clears the parse state and both
// valid flags. A stall on m_axis holds the result register and, through it,
// the input register, so s_axis_tready drops only when both are full.
module http_request_line_parser_unit
    import hrlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] target_byte, [8] accepted,
                                        // [12:9] method_code, [13] version_code,
                                        // [15:14] zero
    output logic        m_axis_tuser,   // target_valid
    output logic        m_axis_tlast    // line_done
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_result;
    logic       advance;
    logic       step;

    // The result register can take a new item when it is empty or being drained.
    assign advance = !r_out_valid || m_axis_tready;
    // The held input item is parsed whenever it can move into the result register.
    assign step = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    hrlp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.target_valid;
    assign m_axis_tlast  = r_out.line_done;
    assign m_axis_tdata  = {2'b00, r_out.version_code, r_out.method_code,
                            r_out.accepted, r_out.target_byte};

    a_verdict_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[13:8] == 6'd0))
        else $error("verdict fields set on a result that does not end the line");

    a_byte_only_in_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("target byte driven outside the target token");

    a_method_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12:9] <= 4'(NUM_METHODS - 1)))
        else $error("method code out of range");

endmodule

[sv/hrlp_parser.sv]
module hrlp_parser
    import hrlp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_result
);

    t_phase     r_phase, n_phase;
    logic [8:0] r_method_cands, n_method_cands;
    logic [3:0] r_pos, n_pos;
    logic [1:0] r_ver_cands, n_ver_cands;
    logic [3:0] r_matched_method, n_matched_method;
    logic       r_method_matched, n_method_matched;

    always_comb begin
        logic       ws;
        logic [7:0] folded;
        logic [3:0] feed_pos;
        logic [3:0] bumped;
        logic [8:0] m_keep;
        logic [1:0] v_keep;
        logic [1:0] v_base;

        ws = is_space(i_byte);
        folded = ((i_byte >= "A") && (i_byte <= "Z")) ? (i_byte + 8'd32) : i_byte;
        // A token starts at position zero when it is entered from its gap.
        feed_pos = ((r_phase == PH_PRE_METHOD) || (r_phase == PH_PRE_VERSION)) ?
                   4'd0 : r_pos;
        bumped = (feed_pos == POS_MAX) ? POS_MAX : (feed_pos + 4'd1);
        v_base = (r_phase == PH_PRE_VERSION) ? 2'b11 : r_ver_cands;

        for (int i = 0; i < NUM_METHODS; i++) begin
            m_keep[i] = (feed_pos < METHOD_LEN[i]) &&
                        (METHOD_TEXT[i][feed_pos[2:0]] == folded);
        end
        for (int i = 0; i < NUM_VERSIONS; i++) begin
            v_keep[i] = (feed_pos < VERSION_LEN) &&
                        (VERSION_TEXT[i][feed_pos[2:0]] == i_byte);
        end

        n_phase = r_phase;
        n_method_cands = r_method_cands;
        n_pos = r_pos;
        n_ver_cands = r_ver_cands;
        n_matched_method = r_matched_method;
        n_method_matched = r_method_matched;
        o_result = '0;

        unique case (r_phase)
            PH_PRE_METHOD, PH_METHOD: begin
                if (!ws) begin
                    n_phase = PH_METHOD;
                    n_method_cands = r_method_cands & m_keep;
                    n_pos = bumped;
                end else if (r_phase == PH_METHOD) begin
                    n_phase = PH_PRE_TARGET;
                end
            end
            PH_PRE_TARGET, PH_TARGET: begin
                if (!ws) begin
                    n_phase = PH_TARGET;
                    o_result.target_valid = 1'b1;
                    o_result.target_byte = i_byte;
                end else if (r_phase == PH_TARGET) begin
                    n_phase = PH_PRE_VERSION;
                end
            end
            PH_PRE_VERSION, PH_VERSION: begin
                if (!ws) begin
                    n_phase = PH_VERSION;
                    n_ver_cands = v_base & v_keep;
                    n_pos = bumped;
                end else if (r_phase == PH_VERSION) begin
                    n_phase = PH_TRAILING;
                end
            end
            default: begin
            end
        endcase

        // A method token closes on whitespace or when the line ends inside it.
        if (((r_phase == PH_METHOD) && ws) || ((n_phase == PH_METHOD) && i_last)) begin
            for (int i = 0; i < NUM_METHODS; i++) begin
                if (n_method_cands[i] && (METHOD_LEN[i] == n_pos)) begin
                    n_matched_method = 4'(i);
                    n_method_matched = 1'b1;
                end
            end
        end
        if (((r_phase == PH_VERSION) && ws) || ((n_phase == PH_VERSION) && i_last)) begin
            if (n_pos != VERSION_LEN) begin
                n_ver_cands = 2'b00;
            end
            n_phase = PH_TRAILING;
        end

        if (i_last) begin
            o_result.line_done = 1'b1;
            if (n_method_matched && (n_phase >= PH_TRAILING) && (n_ver_cands != 2'b00)) begin
                o_result.accepted = 1'b1;
                o_result.method_code = n_matched_method;
                o_result.version_code = n_ver_cands[1];
            end
            n_phase = PH_PRE_METHOD;
            n_method_cands = '1;
            n_pos = '0;
            n_ver_cands = 2'b11;
            n_matched_method = '0;
            n_method_matched = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PRE_METHOD;
            r_method_cands <= '1;
            r_pos <= '0;
            r_ver_cands <= 2'b11;
            r_matched_method <= '0;
            r_method_matched <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_method_cands <= n_method_cands;
            r_pos <= n_pos;
            r_ver_cands <= n_ver_cands;
            r_matched_method <= n_matched_method;
            r_method_matched <= n_method_matched;
        end
    end

    a_line_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> ((r_phase == PH_PRE_METHOD) && (r_method_cands == 9'h1FF)))
        else $error("parser state not cleared after line end");

    a_method_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_method_matched |-> ((r_phase != PH_PRE_METHOD) && (r_phase != PH_METHOD)))
        else $error("method marked matched before its token closed");

    a_version_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VERSION) |-> (r_pos != 4'd0))
        else $error("inside version token with no bytes counted");

endmodule
